[hdl/caesar_vigenere_byte_cipher_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the byte cipher
// Clocked, reset-qualified concurrent assertion wrappers.
// ----------------------------------------------------------------------------
`ifndef CAESAR_VIGENERE_BYTE_CIPHER_MACROS_SVH
`define CAESAR_VIGENERE_BYTE_CIPHER_MACROS_SVH

// Assertion on clk, disabled while rst is high.
`define CVB_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Assertion on clk that also holds through reset.
`define CVB_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

[hdl/cvb_pkg.sv]
// ----------------------------------------------------------------------------
// cvb_pkg
// Shared types and constants of the byte cipher.
// ----------------------------------------------------------------------------
package cvb_pkg;

  localparam int unsigned KEY_W    = 32;
  localparam int unsigned METHOD_W = 2;
  localparam int unsigned BYTE_W   = 8;

  // Configuration register indexes
  localparam logic REG_CIPHER_KEY    = 1'b0;
  localparam logic REG_CIPHER_METHOD = 1'b1;

  // Cipher methods (any other code passes through)
  localparam logic [METHOD_W-1:0] METHOD_CAESAR   = 2'd0;
  localparam logic [METHOD_W-1:0] METHOD_VIGENERE = 2'd1;
  localparam logic [METHOD_W-1:0] METHOD_PASS     = 2'd2;

  // Linear congruential generator
  localparam logic [KEY_W-1:0] LCG_MUL = 32'd214013;
  localparam logic [KEY_W-1:0] LCG_INC = 32'd2531011;

  // Item between the keystream stage and the combine stage
  typedef struct packed {
    logic [BYTE_W-1:0] data_byte;
    logic              decrypt;
    logic              last;
    logic [BYTE_W-1:0] operand;
  } stage_t;

endpackage

[hdl/cvb_keystream.sv]
// ----------------------------------------------------------------------------
// cvb_keystream
// Generator state, operand select and input register stage.
// ----------------------------------------------------------------------------
`include "caesar_vigenere_byte_cipher_macros.svh"

module cvb_keystream
  import cvb_pkg::*;
#(
  parameter int unsigned KEYSTREAM_LENGTH = 32
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                en,
  input  logic                in_valid,
  input  logic [BYTE_W-1:0]   in_byte,
  input  logic                in_decrypt,
  input  logic                in_last,
  input  logic [KEY_W-1:0]    cipher_key,
  input  logic [METHOD_W-1:0] cipher_method,
  output stage_t              st,
  output logic                st_valid
);

  localparam int unsigned POS_W = (KEYSTREAM_LENGTH > 1) ? $clog2(KEYSTREAM_LENGTH) : 1;
  localparam logic [POS_W:0] LEN = (POS_W + 1)'(KEYSTREAM_LENGTH);

  logic [KEY_W-1:0] generator_seed;
  logic [POS_W-1:0] key_position;
  logic [POS_W-1:0] key_position_next;
  logic [KEY_W-1:0] seed_base;
  logic [KEY_W-1:0] seed_next;
  logic [POS_W:0]   pos_inc;
  logic [BYTE_W-1:0] operand;
  logic             accept;

  assign accept    = in_valid & en;
  // period start reloads from the key
  assign seed_base = (key_position == '0) ? cipher_key : generator_seed;
  assign seed_next = seed_base * LCG_MUL + LCG_INC;
  assign pos_inc   = {1'b0, key_position} + 1'b1;

  always_comb begin
    if (in_last || pos_inc >= LEN) begin
      key_position_next = '0;
    end else begin
      key_position_next = pos_inc[POS_W-1:0];
    end
  end

  always_comb begin
    case (cipher_method)
      METHOD_CAESAR:   operand = cipher_key[BYTE_W-1:0];
      METHOD_VIGENERE: operand = seed_next[23:16];
      METHOD_PASS:     operand = '0;
      default:         operand = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      generator_seed <= '0;
      key_position   <= '0;
      st_valid       <= 1'b0;
    end else begin
      if (en) begin
        st_valid <= in_valid;
      end
      if (accept) begin
        generator_seed <= seed_next;
        key_position   <= key_position_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      st.data_byte <= in_byte;
      st.decrypt   <= in_decrypt;
      st.last      <= in_last;
      st.operand   <= operand;
    end
  end

  `CVB_ASSERT(a_last_restarts, accept && in_last |=> key_position == '0, "last byte did not restart period")
  `CVB_ASSERT(a_state_holds, !accept |=> $stable(key_position) && $stable(generator_seed), "state moved without a request")
  `CVB_ASSERT(a_pos_in_range, {1'b0, key_position} < LEN, "key position out of period")

endmodule

[hdl/cvb_combine.sv]
// ----------------------------------------------------------------------------
// cvb_combine
// Byte add or subtract into the output register.
// ----------------------------------------------------------------------------
module cvb_combine
  import cvb_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  stage_t            st,
  input  logic              st_valid,
  output logic              out_valid,
  output logic [BYTE_W-1:0] out_byte,
  output logic              out_last
);

  logic [BYTE_W-1:0] result;

  assign result = st.decrypt ? (st.data_byte - st.operand) : (st.data_byte + st.operand);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= st_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en && st_valid) begin
      out_byte <= result;
      out_last <= st.last;
    end
  end

endmodule

[hdl/caesar_vigenere_byte_cipher.sv]
// ----------------------------------------------------------------------------
// caesar_vigenere_byte_cipher
// Caesar / LCG-keystream Vigenere byte cipher on a stream interface.
// ----------------------------------------------------------------------------
// A request is registered in the keystream stage, then in the output stage.
// Throughput: one byte per cycle when not stalled; the generator multiply-add
//   and state update fit in the input stage: requests follow back to back.
// Backpressure stalls both stages together when the result is not taken.
// Reset (rst, synchronous): key, method, generator and period position go
//   to zero and both stages empty.
// ----------------------------------------------------------------------------
module caesar_vigenere_byte_cipher
  import cvb_pkg::*;
#(
  parameter int unsigned KEYSTREAM_LENGTH = 32
) (
  input  logic              clk,
  input  logic              rst,
  // configuration
  input  logic              cfg_we,
  input  logic              cfg_index,
  input  logic [KEY_W-1:0]  cfg_wdata,
  // input stream
  input  logic              s_tvalid,
  output logic              s_tready,
  input  logic [7:0]        s_tdata,   // [7:0] data_byte
  input  logic              s_tuser,   // [0] mode (1 = decrypt)
  input  logic              s_tlast,   // last_in
  // result stream
  output logic              m_tvalid,
  input  logic              m_tready,
  output logic [7:0]        m_tdata,   // [7:0] result_byte
  output logic              m_tlast    // last_out
);

  logic [KEY_W-1:0]    cipher_key;
  logic [METHOD_W-1:0] cipher_method;
  logic                en;
  stage_t              st;
  logic                st_valid;

  // whole pipe advances unless a result sits unclaimed
  assign en       = !m_tvalid || m_tready;
  assign s_tready = en;

  // configuration registers, the user writes them only while idle (not enforced here)
  always_ff @(posedge clk) begin
    if (rst) begin
      cipher_key    <= '0;
      cipher_method <= METHOD_CAESAR;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_CIPHER_KEY:    cipher_key    <= cfg_wdata;
        REG_CIPHER_METHOD: cipher_method <= cfg_wdata[METHOD_W-1:0];
        default:           cipher_key    <= cipher_key;
      endcase
    end
  end

  // stage 1: generator step and operand pick
  cvb_keystream #(
    .KEYSTREAM_LENGTH(KEYSTREAM_LENGTH)
  ) u_keystream (
    .clk          (clk),
    .rst          (rst),
    .en           (en),
    .in_valid     (s_tvalid),
    .in_byte      (s_tdata),
    .in_decrypt   (s_tuser),
    .in_last      (s_tlast),
    .cipher_key   (cipher_key),
    .cipher_method(cipher_method),
    .st           (st),
    .st_valid     (st_valid)
  );

  // stage 2: modulo-256 add or subtract
  cvb_combine u_combine (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .st       (st),
    .st_valid (st_valid),
    .out_valid(m_tvalid),
    .out_byte (m_tdata),
    .out_last (m_tlast)
  );

endmodule

[test/caesar_vigenere_byte_cipher_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// caesar_vigenere_byte_cipher_checker
// Watches config writes and both stream channels. Predicts each result from
// an independent cipher model and scores results in arrival order.
// ----------------------------------------------------------------------------
module caesar_vigenere_byte_cipher_checker
  import cvb_pkg::*;
#(
  parameter int unsigned KEYSTREAM_LENGTH = 32
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic             cfg_index,
  input  logic [KEY_W-1:0] cfg_wdata,
  input  logic             s_tvalid,
  input  logic             s_tready,
  input  logic [7:0]       s_tdata,   // [7:0] data_byte
  input  logic             s_tuser,   // [0] mode (1 = decrypt)
  input  logic             s_tlast,   // last_in
  input  logic             m_tvalid,
  input  logic             m_tready,
  input  logic [7:0]       m_tdata,   // [7:0] result_byte
  input  logic             m_tlast,   // last_out
  output int               mismatches,
  output int               pending,
  output int               results_checked
);

  typedef struct packed {
    logic [BYTE_W-1:0] result_byte;
    logic              last_out;
  } cipher_result_t;

  cipher_result_t      expected_results[$];

  // shadow of the block's registers and keystream state
  logic [KEY_W-1:0]    key_reg;
  logic [METHOD_W-1:0] method_reg;
  logic [KEY_W-1:0]    lcg_state;
  int unsigned         period_pos;

  // One byte through the cipher; advances the keystream on every method.
  function automatic cipher_result_t cipher_byte(input logic [BYTE_W-1:0] data,
                                                 input logic decrypt,
                                                 input logic last);
    logic [KEY_W-1:0]  next_state;
    logic [BYTE_W-1:0] operand;
    cipher_result_t    res;
    next_state = (period_pos == 0) ? key_reg : lcg_state;
    next_state = next_state * LCG_MUL + LCG_INC;
    lcg_state  = next_state;
    period_pos = (period_pos + 1 >= KEYSTREAM_LENGTH) ? 0 : period_pos + 1;
    case (method_reg)
      METHOD_CAESAR:   operand = key_reg[BYTE_W-1:0];
      METHOD_VIGENERE: operand = next_state[23:16];
      default:         operand = '0;
    endcase
    res.result_byte = decrypt ? data - operand : data + operand;
    res.last_out    = last;
    // end of message: next byte reseeds from the key
    if (last) period_pos = 0;
    return res;
  endfunction

  always @(posedge clk) begin : monitor
    cipher_result_t exp_res;
    if (rst) begin
      expected_results.delete();
      key_reg    = '0;
      method_reg = METHOD_CAESAR;
      lcg_state  = '0;
      period_pos = 0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (expected_results.size() == 0) begin
          mismatches++;
          $error("unexpected result: result_byte %02h last_out %0b", m_tdata, m_tlast);
        end else begin
          exp_res = expected_results.pop_front();
          results_checked++;
          if (m_tdata !== exp_res.result_byte) begin
            mismatches++;
            $error("result_byte: expected %02h, actual %02h", exp_res.result_byte, m_tdata);
          end
          if (m_tlast !== exp_res.last_out) begin
            mismatches++;
            $error("last_out: expected %0b, actual %0b", exp_res.last_out, m_tlast);
          end
        end
      end
      // a request on the same edge as a write still sees the old settings
      if (s_tvalid && s_tready)
        expected_results.push_back(cipher_byte(s_tdata, s_tuser, s_tlast));
      if (cfg_we) begin
        case (cfg_index)
          REG_CIPHER_KEY:    key_reg = cfg_wdata;
          REG_CIPHER_METHOD: method_reg = cfg_wdata[METHOD_W-1:0];
          default: ;
        endcase
      end
    end
    pending = expected_results.size();
  end

endmodule

[test/tb_caesar_vigenere_byte_cipher.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_caesar_vigenere_byte_cipher
// Stimulus and verdict for the byte cipher: a directed pass over the key and
// byte extremes and all four method codes, then randomized messages under
// changing key/method settings with random stalls on both streams.
// ----------------------------------------------------------------------------
module tb_caesar_vigenere_byte_cipher;
  import cvb_pkg::*;

  localparam int unsigned PERIOD_BYTES  = 32;
  localparam int unsigned RANDOM_BYTES  = 1700;
  localparam int unsigned QUIET_TAIL    = 250;     // last bytes run with no idling
  localparam int unsigned SETTLE_CYCLES = 8;       // pipeline is 2 deep
  localparam int unsigned CYCLE_LIMIT   = 400000;

  // method code the block has no name for; behaves as pass-through
  localparam logic [METHOD_W-1:0] METHOD_UNUSED = 2'd3;

  logic             clk       = 1'b0;
  logic             rst       = 1'b1;
  logic             cfg_we    = 1'b0;
  logic             cfg_index = REG_CIPHER_KEY;
  logic [KEY_W-1:0] cfg_wdata = '0;
  logic             s_tvalid  = 1'b0;
  logic             s_tready;
  logic [7:0]       s_tdata   = '0;   // [7:0] data_byte
  logic             s_tuser   = 1'b0; // [0] mode (1 = decrypt)
  logic             s_tlast   = 1'b0; // last_in
  logic             m_tvalid;
  logic             m_tready  = 1'b1;
  logic [7:0]       m_tdata;          // [7:0] result_byte
  logic             m_tlast;          // last_out

  int               mismatches;
  int               pending;
  int               results_checked;

  bit               idle_on = 1'b0;   // random gaps/stalls enabled
  int unsigned      quiet_from = '1;  // byte count from which idling stops
  int unsigned      bytes_sent;
  int unsigned      messages_sent;
  int unsigned      settings_used;
  int unsigned      cycle_count;

  caesar_vigenere_byte_cipher #(
    .KEYSTREAM_LENGTH(PERIOD_BYTES)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  caesar_vigenere_byte_cipher_checker #(
    .KEYSTREAM_LENGTH(PERIOD_BYTES)
  ) u_checker (
    .clk            (clk),
    .rst            (rst),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .s_tvalid       (s_tvalid),
    .s_tready       (s_tready),
    .s_tdata        (s_tdata),
    .s_tuser        (s_tuser),
    .s_tlast        (s_tlast),
    .m_tvalid       (m_tvalid),
    .m_tready       (m_tready),
    .m_tdata        (m_tdata),
    .m_tlast        (m_tlast),
    .mismatches     (mismatches),
    .pending        (pending),
    .results_checked(results_checked)
  );

  always #5 clk = ~clk;

  // Watchdog: bounds the run well beyond the slowest legal schedule.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count, pending);
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Result side backpressure: random stall bursts while idling is on,
  // otherwise always ready.
  initial begin
    forever begin
      @(posedge clk);
      if (idle_on && $urandom_range(0, 9) == 0) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 15)) @(posedge clk);
      end
      m_tready <= 1'b1;
    end
  end

  // Both registers are always written as a pair; only called while idle.
  task automatic write_config(input logic [KEY_W-1:0] key,
                              input logic [METHOD_W-1:0] method);
    cfg_we    <= 1'b1;
    cfg_index <= REG_CIPHER_KEY;
    cfg_wdata <= key;
    @(posedge clk);
    cfg_index <= REG_CIPHER_METHOD;
    cfg_wdata <= KEY_W'(method);
    @(posedge clk);
    cfg_we <= 1'b0;
    settings_used++;
  endtask

  // One byte request; returns at the edge where it is accepted.
  task automatic send_byte(input logic [7:0] data, input logic decrypt,
                           input logic last);
    // final stretch of the run goes without gaps or stalls
    if (bytes_sent >= quiet_from) idle_on = 1'b0;
    if (idle_on && $urandom_range(0, 5) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= data;
    s_tuser  <= decrypt;
    s_tlast  <= last;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    bytes_sent++;
    if (last) messages_sent++;
  endtask

  // Hold off new requests until every result is back, then let the
  // pipeline settle. Config writes follow only this.
  task automatic drain_block();
    s_tvalid <= 1'b0;
    @(posedge clk);   // checker has taken the final request by now
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Random-content message; direction flips now and then inside it.
  // With close == 0 the message is left open across the next config write.
  task automatic send_message(input int unsigned len, input bit close);
    logic decrypt;
    decrypt = 1'($urandom_range(0, 1));
    for (int unsigned i = 0; i < len; i++) begin
      if ($urandom_range(0, 7) == 0) decrypt = ~decrypt;
      send_byte(8'($urandom_range(0, 255)), decrypt, close && (i == len - 1));
    end
  endtask

  // Noise: last flags scattered at random, many one-byte messages.
  task automatic send_noise(input int unsigned len);
    repeat (len) send_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                           1'($urandom_range(0, 1)));
  endtask

  initial begin
    int unsigned         byte_goal;
    int unsigned         pick;
    logic [KEY_W-1:0]    key;
    logic [METHOD_W-1:0] method;

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // --- directed ---
    // reset defaults: Caesar with a zero key
    send_byte(8'h00, 1'b0, 1'b0);
    send_byte(8'hFF, 1'b1, 1'b1);
    drain_block();

    // Caesar, key low byte all ones: wrap on add and on subtract
    write_config(32'h0000_00FF, METHOD_CAESAR);
    send_byte(8'h00, 1'b0, 1'b0);
    send_byte(8'hFF, 1'b0, 1'b0);
    send_byte(8'h01, 1'b1, 1'b0);
    send_byte(8'hFE, 1'b1, 1'b1);
    drain_block();

    // Vigenere, all-ones seed; message left open
    write_config(32'hFFFF_FFFF, METHOD_VIGENERE);
    send_byte(8'h00, 1'b0, 1'b0);
    send_byte(8'hFF, 1'b0, 1'b0);
    send_byte(8'h00, 1'b1, 1'b0);
    send_byte(8'hFF, 1'b1, 1'b0);
    drain_block();

    // pass-through mid-message: keystream still steps underneath
    write_config(32'hFFFF_FFFF, METHOD_PASS);
    send_byte(8'hA5, 1'b0, 1'b0);
    send_byte(8'h5A, 1'b1, 1'b0);
    drain_block();

    // key change mid-message: generator continues, new key waits for reload
    write_config(32'h1234_5678, METHOD_VIGENERE);
    send_byte(8'h3C, 1'b0, 1'b1);
    drain_block();

    // unused method code passes bytes through
    write_config(32'h0000_0000, METHOD_UNUSED);
    send_byte(8'hFF, 1'b0, 1'b0);
    send_byte(8'h00, 1'b1, 1'b1);
    drain_block();

    // fresh message after a last flag reseeds from the (zero) key
    write_config(32'h0000_0000, METHOD_VIGENERE);
    send_byte(8'h00, 1'b0, 1'b0);
    send_byte(8'h00, 1'b0, 1'b1);
    drain_block();

    // --- random phases ---
    // Each phase: new key/method, a few messages, then a full drain.
    byte_goal  = bytes_sent + RANDOM_BYTES;
    quiet_from = byte_goal - QUIET_TAIL;
    while (bytes_sent < byte_goal) begin
      idle_on = (bytes_sent + QUIET_TAIL < byte_goal) && ($urandom_range(0, 3) != 0);

      pick = $urandom_range(0, 7);
      key  = (pick == 0) ? '0 : (pick == 1) ? '1 : KEY_W'($urandom());
      pick = $urandom_range(0, 9);
      if (pick < 2)      method = METHOD_CAESAR;
      else if (pick < 7) method = METHOD_VIGENERE;
      else if (pick < 9) method = METHOD_PASS;
      else               method = METHOD_UNUSED;
      write_config(key, method);

      repeat ($urandom_range(1, 6)) begin
        pick = $urandom_range(0, 15);
        if (pick == 0)      send_message($urandom_range(PERIOD_BYTES + 1, 100), 1'b1);
        else if (pick == 1) send_noise($urandom_range(1, 20));
        else                send_message($urandom_range(1, 40), $urandom_range(0, 5) != 0);
      end
      drain_block();
    end

    $display("Sent %0d bytes in %0d closed messages over %0d key/method settings.",
             bytes_sent, messages_sent, settings_used);
    $display("Checked %0d results, including period reloads and mid-message changes.",
             results_checked);
    if (mismatches == 0 && pending == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
